### rtl/hsv2rgb_pkg.sv
// Shared widths, constants and channel offsets for the HSV to RGB converter.
`default_nettype none

package hsv2rgb_pkg;

  localparam int unsigned HUE_W  = 16;
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned NUM_CH = 3;

  typedef logic [HUE_W-1:0] hue_t;
  typedef logic [PIX_W-1:0] pix_t;

  // whole degrees per circle
  localparam int unsigned DEG_MOD = 360;

  // x mod 360 by reciprocal, x below 2^16
  localparam int unsigned R1_SH  = 25;
  localparam int unsigned R1_MW  = 17;
  localparam int unsigned R1_MUL = (2 ** R1_SH) / DEG_MOD;
  localparam int unsigned R0_W   = 10;
  localparam int unsigned RD_W   = 9;

  // final scale 255 * 60, applied after the fraction bits are shifted out
  localparam int unsigned DIV2   = 15300;
  localparam int unsigned YW     = 22;
  localparam int unsigned R2_SH  = 38;
  localparam int unsigned R2_MW  = 25;
  localparam longint unsigned R2_MUL = (64'd1 << R2_SH) / 64'd15300;

  // sector offset per channel: red, green, blue
  function automatic int unsigned ch_ofs(input int unsigned ch);
    int unsigned ofs;
    case (ch)
      0: ofs = 5;
      1: ofs = 3;
      2: ofs = 1;
      default: ofs = 0;
    endcase
    return ofs;
  endfunction

endpackage

`default_nettype wire

### rtl/hsv_to_rgb_converter.sv
// HSV to RGB converter: eight-stage pipeline using the k-based formula.
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  input   | in_valid, in_stall, in_hue_sixteenths,         | in
//          | in_saturation, in_brightness                   |
//  output  | out_valid, out_stall, out_red, out_green,      | out
//          | out_blue                                       |
//
// One transfer per clock while the output is not stalled.
// Stages: hue reciprocal multiply, remainder, hue wrap, per-channel f,
// s*f multiply, v*(den - s*f) multiply, reciprocal multiply, correction.
// rst_n (synchronous) clears the stage valid bits only.
// A stalled output that holds a valid result freezes the whole pipeline; in_stall follows it.
`default_nettype none

module hsv_to_rgb_converter #(
  parameter int unsigned HUE_FRAC_BITS = 4
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  hsv2rgb_pkg::hue_t   in_hue_sixteenths,
  input  hsv2rgb_pkg::pix_t   in_saturation,
  input  hsv2rgb_pkg::pix_t   in_brightness,
  output logic                out_valid,
  input  wire                 out_stall,
  output hsv2rgb_pkg::pix_t   out_red,
  output hsv2rgb_pkg::pix_t   out_green,
  output hsv2rgb_pkg::pix_t   out_blue
);

  import hsv2rgb_pkg::*;

  localparam int unsigned NSTG         = 8;
  localparam int unsigned SECTOR_UNITS = 60 << HUE_FRAC_BITS;
  localparam int unsigned CIRCLE_UNITS = 6 * SECTOR_UNITS;
  localparam int unsigned KW           = $clog2(2 * CIRCLE_UNITS);
  localparam int unsigned FW           = $clog2(SECTOR_UNITS + 1);
  localparam int unsigned DEN          = 255 * SECTOR_UNITS;
  localparam int unsigned SFW          = $clog2(DEN + 1);
  localparam int unsigned PW           = SFW + PIX_W;
  localparam int unsigned P1W          = HUE_W + R1_MW;
  localparam int unsigned P2W          = YW + R2_MW;
  localparam hue_t        FRAC_MASK    = HUE_W'((32'd1 << HUE_FRAC_BITS) - 32'd1);

  logic [NSTG-1:0] vld_r;
  logic            adv;

  logic [P1W-1:0]   p1_r;
  hue_t             hue1_r;
  logic [R0_W-1:0]  r0_r;
  hue_t             frac2_r;
  logic [KW-1:0]    hm_r;
  logic [FW-1:0]    f_r    [NUM_CH];
  logic [SFW-1:0]   sf_r   [NUM_CH];
  logic [PW-1:0]    p_r    [NUM_CH];
  logic [YW-1:0]    y7_r   [NUM_CH];
  logic [P2W-1:0]   prod_r [NUM_CH];
  pix_t             rgb_r  [NUM_CH];
  pix_t             sat1_r, sat2_r, sat3_r, sat4_r;
  pix_t             val1_r, val2_r, val3_r, val4_r, val5_r;

  hue_t             x_in, x2;
  logic [PIX_W-1:0] q1;
  logic [RD_W-1:0]  rd;
  logic [R0_W-1:0]  r0_nxt;
  logic [KW-1:0]    hm_nxt;
  logic [KW-1:0]    k0_c   [NUM_CH];
  logic [KW-1:0]    k_c    [NUM_CH];
  logic [KW-1:0]    oth_c  [NUM_CH];
  logic [KW-1:0]    m_c    [NUM_CH];
  logic [FW-1:0]    f_nxt  [NUM_CH];
  logic [YW-1:0]    y_c    [NUM_CH];
  pix_t             q2_c   [NUM_CH];
  logic [YW-1:0]    rem_c  [NUM_CH];
  pix_t             rgb_nxt[NUM_CH];

  // pipeline advances unless the output holds an untaken result
  assign adv       = !(vld_r[NSTG-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld_r[NSTG-1];
  assign out_red   = rgb_r[0];
  assign out_green = rgb_r[1];
  assign out_blue  = rgb_r[2];

  always_comb begin
    x_in   = in_hue_sixteenths >> HUE_FRAC_BITS;
    x2     = hue1_r >> HUE_FRAC_BITS;
    q1     = p1_r[R1_SH +: PIX_W];
    r0_nxt = R0_W'(x2 - HUE_W'(q1) * HUE_W'(DEG_MOD));
    rd     = (r0_r >= R0_W'(DEG_MOD)) ? RD_W'(r0_r - R0_W'(DEG_MOD)) : RD_W'(r0_r);
    hm_nxt = (KW'(rd) << HUE_FRAC_BITS) | KW'(frac2_r);
    for (int i = 0; i < NUM_CH; i++) begin
      k0_c[i]  = hm_r + KW'(ch_ofs(i) * SECTOR_UNITS);
      k_c[i]   = (k0_c[i] >= KW'(CIRCLE_UNITS)) ? k0_c[i] - KW'(CIRCLE_UNITS) : k0_c[i];
      oth_c[i] = KW'(4 * SECTOR_UNITS) - k_c[i];
      m_c[i]   = (k_c[i] < oth_c[i]) ? k_c[i] : oth_c[i];
      if (k_c[i] >= KW'(4 * SECTOR_UNITS)) begin
        f_nxt[i] = '0;
      end else if (m_c[i] > KW'(SECTOR_UNITS)) begin
        f_nxt[i] = FW'(SECTOR_UNITS);
      end else begin
        f_nxt[i] = FW'(m_c[i]);
      end
      y_c[i]     = YW'(p_r[i] >> HUE_FRAC_BITS);
      q2_c[i]    = prod_r[i][R2_SH +: PIX_W];
      rem_c[i]   = y7_r[i] - YW'(q2_c[i]) * YW'(DIV2);
      rgb_nxt[i] = (rem_c[i] >= YW'(DIV2)) ? q2_c[i] + PIX_W'(1) : q2_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r    <= P1W'(x_in) * P1W'(R1_MUL);
      hue1_r  <= in_hue_sixteenths;
      sat1_r  <= in_saturation;
      val1_r  <= in_brightness;
      r0_r    <= r0_nxt;
      frac2_r <= hue1_r & FRAC_MASK;
      sat2_r  <= sat1_r;
      val2_r  <= val1_r;
      hm_r    <= hm_nxt;
      sat3_r  <= sat2_r;
      val3_r  <= val2_r;
      sat4_r  <= sat3_r;
      val4_r  <= val3_r;
      val5_r  <= val4_r;
      for (int i = 0; i < NUM_CH; i++) begin
        f_r[i]    <= f_nxt[i];
        sf_r[i]   <= SFW'(sat4_r) * SFW'(f_r[i]);
        p_r[i]    <= PW'(val5_r) * PW'(SFW'(DEN) - sf_r[i]);
        y7_r[i]   <= y_c[i];
        prod_r[i] <= P2W'(y_c[i]) * P2W'(R2_MUL);
        rgb_r[i]  <= rgb_nxt[i];
      end
    end
  end

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(vld_r))
    else $error("stage valid bits moved during a stall");

  a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[1] |-> r0_r < R0_W'(2 * DEG_MOD))
    else $error("hue remainder estimate out of range");

  a_one_full_channel: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] |-> (f_r[0] == '0 || f_r[1] == '0 || f_r[2] == '0))
    else $error("no channel at full value");

  a_div_red: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[6] |-> rem_c[0] < YW'(2 * DIV2))
    else $error("red quotient estimate off by more than one");

  a_div_green: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[6] |-> rem_c[1] < YW'(2 * DIV2))
    else $error("green quotient estimate off by more than one");

  a_div_blue: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[6] |-> rem_c[2] < YW'(2 * DIV2))
    else $error("blue quotient estimate off by more than one");

endmodule

`default_nettype wire
